### design/sicxe_register_alu_exec_defines.svh
// ----------------------------------------------------------------------------
// SIC/XE register ALU assertion macros
// Shared property forms for the execution unit's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef SICXE_REGISTER_ALU_EXEC_DEFINES_SVH
`define SICXE_REGISTER_ALU_EXEC_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define SICXE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define SICXE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/sicxe_pkg.sv
// ----------------------------------------------------------------------------
// SIC/XE execution package
// Word size, opcode and status codes, and the control records shared by the
// top level and the iterative arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sicxe_pkg;

  localparam int WORD_BITS         = 24;
  localparam int REG_COUNT_DEFAULT = 10;
  localparam int CNT_W             = 5;

  localparam logic [3:0] SW_INDEX = 4'd9;
  localparam logic [3:0] A_INDEX  = 4'd0;
  localparam logic [3:0] X_INDEX  = 4'd1;
  localparam logic [3:0] L_INDEX  = 4'd2;
  localparam logic [3:0] B_INDEX  = 4'd3;
  localparam logic [3:0] S_INDEX  = 4'd4;
  localparam logic [3:0] T_INDEX  = 4'd5;

  // Register-form opcodes.
  localparam logic [7:0] OP_ADDR   = 8'h90;
  localparam logic [7:0] OP_SUBR   = 8'h94;
  localparam logic [7:0] OP_MULR   = 8'h98;
  localparam logic [7:0] OP_DIVR   = 8'h9C;
  localparam logic [7:0] OP_COMPR  = 8'hA0;
  localparam logic [7:0] OP_SHIFTR = 8'hA4;
  localparam logic [7:0] OP_SHIFTL = 8'hA8;
  localparam logic [7:0] OP_RMO    = 8'hAC;
  localparam logic [7:0] OP_CLEAR  = 8'hB4;

  // Immediate-form opcodes.
  localparam logic [7:0] OP_LDA  = 8'h00;
  localparam logic [7:0] OP_LDX  = 8'h04;
  localparam logic [7:0] OP_LDL  = 8'h08;
  localparam logic [7:0] OP_ADD  = 8'h18;
  localparam logic [7:0] OP_SUB  = 8'h1C;
  localparam logic [7:0] OP_MUL  = 8'h20;
  localparam logic [7:0] OP_DIV  = 8'h24;
  localparam logic [7:0] OP_COMP = 8'h28;
  localparam logic [7:0] OP_AND  = 8'h40;
  localparam logic [7:0] OP_OR   = 8'h44;
  localparam logic [7:0] OP_LDCH = 8'h50;
  localparam logic [7:0] OP_LDB  = 8'h68;
  localparam logic [7:0] OP_LDS  = 8'h6C;
  localparam logic [7:0] OP_LDT  = 8'h74;
  localparam logic [7:0] OP_HALT = 8'hFF;

  // Result status codes.
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_DIVZERO = 3'd1;
  localparam logic [2:0] ST_BADREG  = 3'd2;
  localparam logic [2:0] ST_UNSUP   = 3'd3;
  localparam logic [2:0] ST_HALTED  = 3'd4;

  // Operations of the shared iterative unit.
  localparam logic [2:0] UOP_ADD = 3'd0;
  localparam logic [2:0] UOP_SUB = 3'd1;
  localparam logic [2:0] UOP_MUL = 3'd2;
  localparam logic [2:0] UOP_DIV = 3'd3;
  localparam logic [2:0] UOP_CMP = 3'd4;
  localparam logic [2:0] UOP_ROR = 3'd5;
  localparam logic [2:0] UOP_ROL = 3'd6;

  typedef struct packed {
    logic             start;
    logic [2:0]       uop;
    logic [CNT_W-1:0] count;
  } unit_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

`default_nettype wire

### design/sicxe_iter_unit.sv
// ----------------------------------------------------------------------------
// SIC/XE iterative arithmetic unit
// One shared adder drives add, subtract, compare, shift-add multiply and
// restoring signed divide; rotates move one bit at a time without it.
// ----------------------------------------------------------------------------
`default_nettype none

module sicxe_iter_unit (
  input  wire                                  clk,
  input  wire                                  rst,
  input  sicxe_pkg::unit_cmd_t                 cmd,
  input  wire [sicxe_pkg::WORD_BITS-1:0]       opx_in,
  input  wire [sicxe_pkg::WORD_BITS-1:0]       opy_in,
  output sicxe_pkg::unit_stat_t                stat,
  output logic [sicxe_pkg::WORD_BITS-1:0]      result
);

  localparam int W  = sicxe_pkg::WORD_BITS;
  localparam int AW = W + 2;
  localparam int CW = sicxe_pkg::CNT_W;

  localparam logic [2:0] U_IDLE   = 3'd0;
  localparam logic [2:0] U_PREP_X = 3'd1;
  localparam logic [2:0] U_PREP_Y = 3'd2;
  localparam logic [2:0] U_RUN    = 3'd3;
  localparam logic [2:0] U_FIX    = 3'd4;
  localparam logic [2:0] U_DONE   = 3'd5;

  logic [2:0]    ustate;
  logic [2:0]    uop;
  logic [W-1:0]  acc;
  logic [W-1:0]  opx;
  logic [W-1:0]  opy;
  logic [CW-1:0] cnt;
  logic          neg_q;

  logic [AW-1:0] add_a;
  logic [AW-1:0] add_b;
  logic          add_sub;
  logic [AW-1:0] sum;

  // Operand selection for the single shared adder.
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    case (ustate)
      U_PREP_X: begin
        add_b   = AW'(opx);
        add_sub = 1'b1;
      end
      U_PREP_Y: begin
        add_b   = AW'(opy);
        add_sub = 1'b1;
      end
      U_FIX: begin
        add_b   = AW'(opx);
        add_sub = 1'b1;
      end
      U_RUN: begin
        case (uop)
          sicxe_pkg::UOP_ADD: begin
            add_a = AW'(opx);
            add_b = AW'(opy);
          end
          sicxe_pkg::UOP_SUB: begin
            add_a   = AW'(opx);
            add_b   = AW'(opy);
            add_sub = 1'b1;
          end
          sicxe_pkg::UOP_CMP: begin
            add_a   = {{2{opx[W-1]}}, opx};
            add_b   = {{2{opy[W-1]}}, opy};
            add_sub = 1'b1;
          end
          sicxe_pkg::UOP_MUL: begin
            add_a = AW'(acc);
            add_b = opy[0] ? AW'(opx) : '0;
          end
          sicxe_pkg::UOP_DIV: begin
            add_a   = {1'b0, acc, opx[W-1]};
            add_b   = AW'(opy);
            add_sub = 1'b1;
          end
          default: begin
            add_a = '0;
          end
        endcase
      end
      default: begin
        add_a = '0;
      end
    endcase
  end

  assign sum = add_a + (add_sub ? ~add_b : add_b) + AW'(add_sub);

  always_ff @(posedge clk) begin
    if (rst) begin
      ustate <= U_IDLE;
    end else begin
      case (ustate)
        U_IDLE: begin
          if (cmd.start) begin
            uop   <= cmd.uop;
            opx   <= opx_in;
            opy   <= opy_in;
            acc   <= '0;
            neg_q <= opx_in[W-1] ^ opy_in[W-1];
            case (cmd.uop)
              sicxe_pkg::UOP_MUL, sicxe_pkg::UOP_DIV: cnt <= CW'(W);
              sicxe_pkg::UOP_ROR, sicxe_pkg::UOP_ROL: cnt <= cmd.count;
              default:                                 cnt <= CW'(1);
            endcase
            if (cmd.uop == sicxe_pkg::UOP_DIV) begin
              ustate <= U_PREP_X;
            end else if ((cmd.uop == sicxe_pkg::UOP_ROR || cmd.uop == sicxe_pkg::UOP_ROL)
                         && cmd.count == '0) begin
              ustate <= U_DONE;
            end else begin
              ustate <= U_RUN;
            end
          end
        end
        U_PREP_X: begin
          // Take the magnitude of the dividend.
          if (opx[W-1]) begin
            opx <= sum[W-1:0];
          end
          ustate <= U_PREP_Y;
        end
        U_PREP_Y: begin
          if (opy[W-1]) begin
            opy <= sum[W-1:0];
          end
          ustate <= U_RUN;
        end
        U_RUN: begin
          case (uop)
            sicxe_pkg::UOP_ADD, sicxe_pkg::UOP_SUB: begin
              acc <= sum[W-1:0];
            end
            sicxe_pkg::UOP_CMP: begin
              if (sum == '0) begin
                acc <= '0;
              end else if (sum[AW-1]) begin
                acc <= '1;
              end else begin
                acc <= W'(1);
              end
            end
            sicxe_pkg::UOP_MUL: begin
              acc <= sum[W-1:0];
              opx <= {opx[W-2:0], 1'b0};
              opy <= {1'b0, opy[W-1:1]};
            end
            sicxe_pkg::UOP_DIV: begin
              // Restoring step: the quotient bit enters opx as the dividend leaves.
              if (!sum[AW-1]) begin
                acc <= sum[W-1:0];
                opx <= {opx[W-2:0], 1'b1};
              end else begin
                acc <= {acc[W-2:0], opx[W-1]};
                opx <= {opx[W-2:0], 1'b0};
              end
            end
            sicxe_pkg::UOP_ROR: begin
              opx <= {opx[0], opx[W-1:1]};
            end
            sicxe_pkg::UOP_ROL: begin
              opx <= {opx[W-2:0], opx[W-1]};
            end
            default: begin
              acc <= acc;
            end
          endcase
          cnt <= cnt - CW'(1);
          if (cnt == CW'(1)) begin
            ustate <= (uop == sicxe_pkg::UOP_DIV) ? U_FIX : U_DONE;
          end
        end
        U_FIX: begin
          acc    <= neg_q ? sum[W-1:0] : opx;
          ustate <= U_DONE;
        end
        U_DONE: begin
          ustate <= U_IDLE;
        end
        default: begin
          ustate <= U_IDLE;
        end
      endcase
    end
  end

  assign result    = (uop == sicxe_pkg::UOP_ROR || uop == sicxe_pkg::UOP_ROL) ? opx : acc;
  assign stat.busy = (ustate != U_IDLE);
  assign stat.done = (ustate == U_DONE);

endmodule

`default_nettype wire

### design/sicxe_register_alu_exec.sv
// The block executes one decoded SIC/XE integer instruction per input
// transaction and returns exactly one result transaction for it. It holds
// one transaction at a time: after an input is taken, in_stall stays high
// until the result has been placed in the output register. Loads, moves,
// CLEAR, AND, OR and every error or halt report go from S_READ straight
// to S_FIN and on to the output register. Add, subtract and compare go
// through the shared arithmetic unit while the sequencer waits in S_WAIT;
// a rotate by n takes n single-bit steps there (none when n is zero); a
// multiply takes one shift-add step per bit; a divide forms the operand
// magnitudes, then takes 24 restoring steps and one sign fix, all on the
// same adder. A result may wait in the output register while the next
// input is executed; the block only pauses before writing back if that
// earlier result has not yet been taken. The register file is a small
// memory written at one port and read at two; its contents read as zero
// until an entry is first written after reset, so no clearing pass is
// needed.
// ----------------------------------------------------------------------------
// SIC/XE register ALU execution unit
// Sequencer, register file and result register around the iterative unit.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sicxe_register_alu_exec_defines.svh"

module sicxe_register_alu_exec #(
  parameter int REG_COUNT = sicxe_pkg::REG_COUNT_DEFAULT
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  wire [7:0]                            opcode,
  input  wire [3:0]                            reg_first,
  input  wire [3:0]                            reg_second,
  input  wire [sicxe_pkg::WORD_BITS-1:0]       immediate,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output logic [3:0]                           dest_index,
  output logic [sicxe_pkg::WORD_BITS-1:0]      dest_value,
  output logic                                 wrote,
  output logic [2:0]                           status
);

  localparam int W     = sicxe_pkg::WORD_BITS;
  localparam int CW    = sicxe_pkg::CNT_W;
  localparam int IDX_W = $clog2(REG_COUNT);
  localparam logic [4:0] REG_LIMIT = 5'(REG_COUNT);

  // Sequencer states.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0] state;
  logic       halted;

  // Register file, with a written mark per entry so that reset reads as zero.
  logic [W-1:0]         mem [REG_COUNT];
  logic [REG_COUNT-1:0] vld;

  logic [IDX_W-1:0] addr_a;
  logic [IDX_W-1:0] addr_b;
  logic [W-1:0]     rd_a_word;
  logic [W-1:0]     rd_b_word;
  logic             rd_a_vld;
  logic             rd_b_vld;

  // Captured instruction fields.
  logic [7:0]   op_r;
  logic [3:0]   r1_r;
  logic [3:0]   r2_r;
  logic [W-1:0] imm_r;

  // Result waiting for write-back.
  logic [3:0]   pend_dst;
  logic [W-1:0] pend_val;
  logic         pend_wr;
  logic [2:0]   pend_status;

  logic accept;
  logic out_free;
  logic fin_go;

  // Decode results.
  logic [W-1:0]  ra;
  logic [W-1:0]  rb;
  logic          r1_ok;
  logic          r2_ok;
  logic          d_unit;
  logic [2:0]    d_uop;
  logic [W-1:0]  d_ux;
  logic [W-1:0]  d_uy;
  logic [CW-1:0] d_cnt;
  logic [3:0]    d_dst;
  logic [W-1:0]  d_val;
  logic          d_wr;
  logic [2:0]    d_status;
  logic          d_halt;

  sicxe_pkg::unit_cmd_t  ucmd;
  sicxe_pkg::unit_stat_t ustat;
  logic [W-1:0]          u_result;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign fin_go   = (state == S_FIN) && out_free;

  // Register forms have the top opcode bit set and read r1 on port A;
  // immediate forms read A on that port instead.
  assign addr_a = opcode[7] ? reg_first[IDX_W-1:0] : IDX_W'(0);
  assign addr_b = reg_second[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_a_word <= mem[addr_a];
      rd_b_word <= mem[addr_b];
      rd_a_vld  <= vld[addr_a];
      rd_b_vld  <= vld[addr_b];
      op_r      <= opcode;
      r1_r      <= reg_first;
      r2_r      <= reg_second;
      imm_r     <= immediate;
    end
    if (fin_go && pend_wr) begin
      mem[pend_dst[IDX_W-1:0]] <= pend_val;
    end
  end

  assign ra    = rd_a_vld ? rd_a_word : '0;
  assign rb    = rd_b_vld ? rd_b_word : '0;
  assign r1_ok = {1'b0, r1_r} < REG_LIMIT;
  assign r2_ok = {1'b0, r2_r} < REG_LIMIT;

  // Instruction decode: either a direct result, an error report, or a job
  // for the iterative unit.
  always_comb begin
    d_unit   = 1'b0;
    d_uop    = sicxe_pkg::UOP_ADD;
    d_ux     = ra;
    d_uy     = rb;
    d_cnt    = '0;
    d_dst    = '0;
    d_val    = '0;
    d_wr     = 1'b0;
    d_status = sicxe_pkg::ST_OK;
    d_halt   = 1'b0;
    if (halted) begin
      d_status = sicxe_pkg::ST_HALTED;
    end else if (op_r == sicxe_pkg::OP_HALT) begin
      d_halt   = 1'b1;
      d_status = sicxe_pkg::ST_HALTED;
    end else begin
      case (op_r)
        sicxe_pkg::OP_ADDR, sicxe_pkg::OP_SUBR, sicxe_pkg::OP_MULR,
        sicxe_pkg::OP_DIVR, sicxe_pkg::OP_COMPR, sicxe_pkg::OP_RMO: begin
          if (!(r1_ok && r2_ok)) begin
            d_status = sicxe_pkg::ST_BADREG;
          end else begin
            case (op_r)
              sicxe_pkg::OP_ADDR: begin
                d_unit = 1'b1;
                d_uop  = sicxe_pkg::UOP_ADD;
                d_ux   = rb;
                d_uy   = ra;
                d_dst  = r2_r;
                d_wr   = 1'b1;
              end
              sicxe_pkg::OP_SUBR: begin
                d_unit = 1'b1;
                d_uop  = sicxe_pkg::UOP_SUB;
                d_ux   = rb;
                d_uy   = ra;
                d_dst  = r2_r;
                d_wr   = 1'b1;
              end
              sicxe_pkg::OP_MULR: begin
                d_unit = 1'b1;
                d_uop  = sicxe_pkg::UOP_MUL;
                d_ux   = rb;
                d_uy   = ra;
                d_dst  = r2_r;
                d_wr   = 1'b1;
              end
              sicxe_pkg::OP_DIVR: begin
                if (ra == '0) begin
                  d_status = sicxe_pkg::ST_DIVZERO;
                end else begin
                  d_unit = 1'b1;
                  d_uop  = sicxe_pkg::UOP_DIV;
                  d_ux   = rb;
                  d_uy   = ra;
                  d_dst  = r2_r;
                  d_wr   = 1'b1;
                end
              end
              sicxe_pkg::OP_COMPR: begin
                d_unit = 1'b1;
                d_uop  = sicxe_pkg::UOP_CMP;
                d_ux   = ra;
                d_uy   = rb;
                d_dst  = sicxe_pkg::SW_INDEX;
                d_wr   = 1'b1;
              end
              default: begin
                d_val = ra;
                d_dst = r2_r;
                d_wr  = 1'b1;
              end
            endcase
          end
        end
        sicxe_pkg::OP_SHIFTR, sicxe_pkg::OP_SHIFTL, sicxe_pkg::OP_CLEAR: begin
          if (!r1_ok) begin
            d_status = sicxe_pkg::ST_BADREG;
          end else begin
            d_dst = r1_r;
            d_wr  = 1'b1;
            d_ux  = ra;
            d_cnt = CW'(r2_r);
            if (op_r == sicxe_pkg::OP_SHIFTR) begin
              d_unit = 1'b1;
              d_uop  = sicxe_pkg::UOP_ROR;
            end else if (op_r == sicxe_pkg::OP_SHIFTL) begin
              d_unit = 1'b1;
              d_uop  = sicxe_pkg::UOP_ROL;
            end
          end
        end
        sicxe_pkg::OP_LDA: begin
          d_dst = sicxe_pkg::A_INDEX;
          d_val = imm_r;
          d_wr  = 1'b1;
        end
        sicxe_pkg::OP_LDX: begin
          d_dst = sicxe_pkg::X_INDEX;
          d_val = imm_r;
          d_wr  = 1'b1;
        end
        sicxe_pkg::OP_LDL: begin
          d_dst = sicxe_pkg::L_INDEX;
          d_val = imm_r;
          d_wr  = 1'b1;
        end
        sicxe_pkg::OP_LDB: begin
          d_dst = sicxe_pkg::B_INDEX;
          d_val = imm_r;
          d_wr  = 1'b1;
        end
        sicxe_pkg::OP_LDS: begin
          d_dst = sicxe_pkg::S_INDEX;
          d_val = imm_r;
          d_wr  = 1'b1;
        end
        sicxe_pkg::OP_LDT: begin
          d_dst = sicxe_pkg::T_INDEX;
          d_val = imm_r;
          d_wr  = 1'b1;
        end
        sicxe_pkg::OP_LDCH: begin
          d_dst = sicxe_pkg::A_INDEX;
          d_val = W'(imm_r[7:0]);
          d_wr  = 1'b1;
        end
        sicxe_pkg::OP_ADD: begin
          d_unit = 1'b1;
          d_uop  = sicxe_pkg::UOP_ADD;
          d_uy   = imm_r;
          d_dst  = sicxe_pkg::A_INDEX;
          d_wr   = 1'b1;
        end
        sicxe_pkg::OP_SUB: begin
          d_unit = 1'b1;
          d_uop  = sicxe_pkg::UOP_SUB;
          d_uy   = imm_r;
          d_dst  = sicxe_pkg::A_INDEX;
          d_wr   = 1'b1;
        end
        sicxe_pkg::OP_MUL: begin
          d_unit = 1'b1;
          d_uop  = sicxe_pkg::UOP_MUL;
          d_uy   = imm_r;
          d_dst  = sicxe_pkg::A_INDEX;
          d_wr   = 1'b1;
        end
        sicxe_pkg::OP_DIV: begin
          if (imm_r == '0) begin
            d_status = sicxe_pkg::ST_DIVZERO;
          end else begin
            d_unit = 1'b1;
            d_uop  = sicxe_pkg::UOP_DIV;
            d_uy   = imm_r;
            d_dst  = sicxe_pkg::A_INDEX;
            d_wr   = 1'b1;
          end
        end
        sicxe_pkg::OP_COMP: begin
          d_unit = 1'b1;
          d_uop  = sicxe_pkg::UOP_CMP;
          d_uy   = imm_r;
          d_dst  = sicxe_pkg::SW_INDEX;
          d_wr   = 1'b1;
        end
        sicxe_pkg::OP_AND: begin
          d_dst = sicxe_pkg::A_INDEX;
          d_val = ra & imm_r;
          d_wr  = 1'b1;
        end
        sicxe_pkg::OP_OR: begin
          d_dst = sicxe_pkg::A_INDEX;
          d_val = ra | imm_r;
          d_wr  = 1'b1;
        end
        default: begin
          d_status = sicxe_pkg::ST_UNSUP;
        end
      endcase
    end
  end

  assign ucmd.start = (state == S_READ) && d_unit;
  assign ucmd.uop   = d_uop;
  assign ucmd.count = d_cnt;

  sicxe_iter_unit u_iter (
    .clk    (clk),
    .rst    (rst),
    .cmd    (ucmd),
    .opx_in (d_ux),
    .opy_in (d_uy),
    .stat   (ustat),
    .result (u_result)
  );

  // Sequencer, halt flag and written marks.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      halted <= 1'b0;
      vld    <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          halted <= halted | d_halt;
          state  <= d_unit ? S_WAIT : S_FIN;
        end
        S_WAIT: begin
          if (ustat.done) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
            if (pend_wr) begin
              vld[pend_dst[IDX_W-1:0]] <= 1'b1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Pending result fields.
  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      pend_dst    <= d_dst;
      pend_val    <= d_val;
      pend_wr     <= d_wr;
      pend_status <= d_status;
    end else if (state == S_WAIT && ustat.done) begin
      pend_val <= u_result;
    end
  end

  // Output register: holds one result transaction until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      dest_index <= pend_dst;
      dest_value <= pend_val;
      wrote      <= pend_wr;
      status     <= pend_status;
    end
  end

  `SICXE_ASSERT_IMP(a_unit_idle, (state == S_IDLE), !ustat.busy, "unit busy while idle")
  `SICXE_ASSERT_IMP(a_nowrite_zero, (out_valid && !wrote),
                    (dest_index == 4'd0 && dest_value == '0), "nonzero result without write")
  `SICXE_ASSERT_NXT(a_halt_sticky, halted, halted, "halt flag cleared without reset")
  `SICXE_ASSERT_NXT(a_accept_read, accept, (state == S_READ), "accepted transaction not read")

endmodule

`default_nettype wire

### verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SIC/XE register ALU execution unit testbench
// Feeds decoded integer instructions to the execution unit while both
// handshakes idle at random. A scoreboard keeps its own copy of the register
// file and the halt flag, and checks every result transaction in order.
// ----------------------------------------------------------------------------

module tb;

  localparam int WORD_BITS     = sicxe_pkg::WORD_BITS;
  // The block is built with the default register count.
  localparam int REG_LIMIT     = sicxe_pkg::REG_COUNT_DEFAULT;
  localparam int RANDOM_INSTRS = 620;
  // The slowest instruction is a divide, so this covers anything still in
  // flight once the last expected result has arrived.
  localparam int DRAIN_CYCLES  = 40;
  // Receiver hold-off: periodically it refuses results while the sender keeps offering instructions.
  localparam int HOLD_PERIOD   = 3000;
  localparam int HOLD_CYCLES   = 160;

  typedef logic [WORD_BITS-1:0] word_t;

  localparam word_t MAX_POS = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t MIN_NEG = {1'b1, {(WORD_BITS-1){1'b0}}};

  // One result transaction as the block presents it.
  typedef struct packed {
    logic [3:0] reg_idx;
    word_t      value;
    logic       written;
    logic [2:0] code;
  } writeback_t;

  // The scoreboard executes each accepted instruction on its own register
  // file and queues the writeback that the block has to report for it.
  class exec_scoreboard;
    word_t      regs [16];
    bit         halted;
    writeback_t pending_writebacks [$];
    int         mismatch_count;

    function new();
      foreach (regs[i]) regs[i] = '0;
      halted         = 1'b0;
      mismatch_count = 0;
    endfunction

    // Signed division truncating toward zero. The most negative word over
    // minus one wraps back to itself when cut down to the word width.
    function word_t quotient(word_t dividend, word_t divisor);
      int signed num;
      int signed den;
      int signed quo;
      num = $signed(dividend);
      den = $signed(divisor);
      quo = num / den;
      return quo[WORD_BITS-1:0];
    endfunction

    // Status word of a compare: 1, 0 or -1 as the signed left side is
    // greater than, equal to or less than the right side.
    function word_t signed_order(word_t lhs, word_t rhs);
      if ($signed(lhs) > $signed(rhs)) return word_t'(1);
      if (lhs == rhs) return '0;
      return '1;
    endfunction

    function void note_instr(logic [7:0] op, logic [3:0] r1, logic [3:0] r2, word_t imm);
      writeback_t             res;
      word_t                  a;
      word_t                  b;
      logic [2*WORD_BITS-1:0] pair;
      res = '0;
      a   = regs[r1];
      b   = regs[r2];
      if (halted || op == sicxe_pkg::OP_HALT) begin
        // Halt sticks until reset; nothing executes after it.
        halted   = 1'b1;
        res.code = sicxe_pkg::ST_HALTED;
      end else begin
        res.written = 1'b1;
        case (op)
          sicxe_pkg::OP_ADDR, sicxe_pkg::OP_SUBR, sicxe_pkg::OP_MULR,
          sicxe_pkg::OP_DIVR, sicxe_pkg::OP_COMPR, sicxe_pkg::OP_RMO: begin
            res.reg_idx = r2;
            if (r1 >= REG_LIMIT || r2 >= REG_LIMIT) res.code = sicxe_pkg::ST_BADREG;
            else if (op == sicxe_pkg::OP_DIVR && a == '0) res.code = sicxe_pkg::ST_DIVZERO;
            else begin
              case (op)
                sicxe_pkg::OP_ADDR: res.value = b + a;
                sicxe_pkg::OP_SUBR: res.value = b - a;
                sicxe_pkg::OP_MULR: res.value = b * a;
                sicxe_pkg::OP_DIVR: res.value = quotient(b, a);
                sicxe_pkg::OP_COMPR: begin
                  res.reg_idx = sicxe_pkg::SW_INDEX;
                  res.value   = signed_order(a, b);
                end
                default: res.value = a;
              endcase
            end
          end
          sicxe_pkg::OP_SHIFTR, sicxe_pkg::OP_SHIFTL, sicxe_pkg::OP_CLEAR: begin
            // Only r1 is a register here; r2 is the rotate count.
            res.reg_idx = r1;
            if (r1 >= REG_LIMIT) res.code = sicxe_pkg::ST_BADREG;
            else if (op == sicxe_pkg::OP_SHIFTR) begin
              pair      = {a, a} >> r2;
              res.value = pair[WORD_BITS-1:0];
            end else if (op == sicxe_pkg::OP_SHIFTL) begin
              pair      = {a, a} << r2;
              res.value = pair[2*WORD_BITS-1:WORD_BITS];
            end
          end
          sicxe_pkg::OP_LDA: res.value = imm;
          sicxe_pkg::OP_LDX: begin
            res.reg_idx = sicxe_pkg::X_INDEX;
            res.value   = imm;
          end
          sicxe_pkg::OP_LDL: begin
            res.reg_idx = sicxe_pkg::L_INDEX;
            res.value   = imm;
          end
          sicxe_pkg::OP_LDB: begin
            res.reg_idx = sicxe_pkg::B_INDEX;
            res.value   = imm;
          end
          sicxe_pkg::OP_LDS: begin
            res.reg_idx = sicxe_pkg::S_INDEX;
            res.value   = imm;
          end
          sicxe_pkg::OP_LDT: begin
            res.reg_idx = sicxe_pkg::T_INDEX;
            res.value   = imm;
          end
          sicxe_pkg::OP_LDCH: res.value = imm & word_t'(8'hFF);
          sicxe_pkg::OP_ADD:  res.value = regs[sicxe_pkg::A_INDEX] + imm;
          sicxe_pkg::OP_SUB:  res.value = regs[sicxe_pkg::A_INDEX] - imm;
          sicxe_pkg::OP_MUL:  res.value = regs[sicxe_pkg::A_INDEX] * imm;
          sicxe_pkg::OP_AND:  res.value = regs[sicxe_pkg::A_INDEX] & imm;
          sicxe_pkg::OP_OR:   res.value = regs[sicxe_pkg::A_INDEX] | imm;
          sicxe_pkg::OP_DIV: begin
            if (imm == '0) res.code = sicxe_pkg::ST_DIVZERO;
            else res.value = quotient(regs[sicxe_pkg::A_INDEX], imm);
          end
          sicxe_pkg::OP_COMP: begin
            res.reg_idx = sicxe_pkg::SW_INDEX;
            res.value   = signed_order(regs[sicxe_pkg::A_INDEX], imm);
          end
          default: res.code = sicxe_pkg::ST_UNSUP;
        endcase
        // Any error leaves the file untouched and reports an empty write.
        if (res.code == sicxe_pkg::ST_OK) regs[res.reg_idx] = res.value;
        else begin
          res.reg_idx = '0;
          res.value   = '0;
          res.written = 1'b0;
        end
      end
      pending_writebacks.push_back(res);
    endfunction

    task flag(string msg);
      mismatch_count++;
      $display("%0t: %s", $time, msg);
    endtask

    task check_writeback(writeback_t got);
      writeback_t want;
      if (pending_writebacks.size() == 0) begin
        flag($sformatf("result with none outstanding: idx %0d value %h wrote %b status %0d",
                       got.reg_idx, got.value, got.written, got.code));
        return;
      end
      want = pending_writebacks.pop_front();
      if (got.reg_idx !== want.reg_idx || got.value !== want.value ||
          got.written !== want.written || got.code !== want.code)
        flag($sformatf("got idx %0d value %h wrote %b status %0d, want %0d %h %b %0d",
                       got.reg_idx, got.value, got.written, got.code,
                       want.reg_idx, want.value, want.written, want.code));
    endtask
  endclass

  // Clock, reset and every block input start at known values.
  logic       clk        = 1'b0;
  logic       rst        = 1'b1;
  logic       in_valid   = 1'b0;
  logic [7:0] opcode     = '0;
  logic [3:0] reg_first  = '0;
  logic [3:0] reg_second = '0;
  word_t      immediate  = '0;
  logic       out_stall  = 1'b0;

  logic       in_stall;
  logic       out_valid;
  logic [3:0] dest_index;
  word_t      dest_value;
  logic       wrote;
  logic [2:0] status;

  exec_scoreboard tracker = new();

  // Sender burst state and receiver stall pattern state.
  int burst_left = 0;
  int cycle_count = 0;
  int stall_mode = 0;
  int mode_left = 0;
  int hold_left = 0;

  logic [7:0] load_ops [7] = '{sicxe_pkg::OP_LDA, sicxe_pkg::OP_LDX, sicxe_pkg::OP_LDL,
                               sicxe_pkg::OP_LDB, sicxe_pkg::OP_LDS, sicxe_pkg::OP_LDT,
                               sicxe_pkg::OP_LDCH};
  logic [7:0] reg_ops  [9] = '{sicxe_pkg::OP_ADDR, sicxe_pkg::OP_SUBR, sicxe_pkg::OP_MULR,
                               sicxe_pkg::OP_DIVR, sicxe_pkg::OP_COMPR, sicxe_pkg::OP_SHIFTR,
                               sicxe_pkg::OP_SHIFTL, sicxe_pkg::OP_RMO, sicxe_pkg::OP_CLEAR};
  logic [7:0] imm_ops  [7] = '{sicxe_pkg::OP_ADD, sicxe_pkg::OP_SUB, sicxe_pkg::OP_MUL,
                               sicxe_pkg::OP_DIV, sicxe_pkg::OP_COMP, sicxe_pkg::OP_AND,
                               sicxe_pkg::OP_OR};

  sicxe_register_alu_exec dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .opcode     (opcode),
    .reg_first  (reg_first),
    .reg_second (reg_second),
    .immediate  (immediate),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .dest_index (dest_index),
    .dest_value (dest_value),
    .wrote      (wrote),
    .status     (status)
  );

  always #5 clk = ~clk;

  // Operand words lean on the edges of the signed range and on small
  // values, so that wrap, sign and divide-by-zero cases come up often.
  function automatic word_t pick_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return word_t'(1);
      2: return MAX_POS;
      3: return MIN_NEG;
      4: return '1;
      5: return word_t'($urandom_range(0, 15));
      default: return word_t'($urandom);
    endcase
  endfunction

  // Register indexes are mostly valid; about one in ten is out of range.
  function automatic logic [3:0] pick_reg();
    if ($urandom_range(0, 9) == 0) return 4'($urandom_range(REG_LIMIT, 15));
    return 4'($urandom_range(0, REG_LIMIT - 1));
  endfunction

  // Presents one instruction and holds it until the block takes the
  // transaction. Between bursts the sender may drop valid for a random gap.
  task automatic send_instr(input logic [7:0] op, input logic [3:0] r1,
                            input logic [3:0] r2, input word_t imm);
    int gap;
    opcode     <= op;
    reg_first  <= r1;
    reg_second <= r2;
    immediate  <= imm;
    in_valid   <= 1'b1;
    do @(posedge clk); while (in_stall);
    tracker.note_instr(op, r1, r2, imm);
    if (burst_left > 0) burst_left--;
    else begin
      // Now and then a long burst gives a stretch with no input gaps.
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                              : $urandom_range(0, 10);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Receiver: checks each result transaction taken at this edge, then
  // decides the stall for the next one. The stall pattern switches between
  // never stalling, light and heavy random stalling and a fixed duty cycle.
  // Periodically it holds off for a long stretch so that the result
  // register stays full, the block backs up and its input stalls.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall)
        tracker.check_writeback({dest_index, dest_value, wrote, status});
      cycle_count++;
      if (cycle_count % HOLD_PERIOD == HOLD_PERIOD / 2) hold_left = HOLD_CYCLES;
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(20, 120);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= (cycle_count % 5 < 2);
        endcase
      end
    end
  end

  initial begin : stimulus
    int         roll;
    logic [7:0] op;
    logic [3:0] r1;
    logic [3:0] r2;
    word_t      imm;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part. Build the extremes in registers and hit overflow on
    // add, the most negative word divided by minus one, a multiply that
    // wraps, compares both ways, and divide by zero in both forms.
    send_instr(sicxe_pkg::OP_LDA, 4'd0, 4'd0, MAX_POS);
    send_instr(sicxe_pkg::OP_LDX, 4'd0, 4'd0, word_t'(1));
    send_instr(sicxe_pkg::OP_ADDR, sicxe_pkg::X_INDEX, sicxe_pkg::A_INDEX, '0);
    send_instr(sicxe_pkg::OP_LDL, 4'd0, 4'd0, '1);
    send_instr(sicxe_pkg::OP_DIVR, sicxe_pkg::L_INDEX, sicxe_pkg::A_INDEX, '0);
    send_instr(sicxe_pkg::OP_LDB, 4'd0, 4'd0, MIN_NEG);
    send_instr(sicxe_pkg::OP_MULR, sicxe_pkg::B_INDEX, sicxe_pkg::L_INDEX, '0);
    send_instr(sicxe_pkg::OP_SUBR, sicxe_pkg::X_INDEX, sicxe_pkg::B_INDEX, '0);
    send_instr(sicxe_pkg::OP_COMPR, sicxe_pkg::A_INDEX, sicxe_pkg::B_INDEX, '0);
    send_instr(sicxe_pkg::OP_COMP, 4'd0, 4'd0, MIN_NEG);
    send_instr(sicxe_pkg::OP_LDS, 4'd0, 4'd0, '0);
    send_instr(sicxe_pkg::OP_DIVR, sicxe_pkg::S_INDEX, sicxe_pkg::A_INDEX, '0);
    send_instr(sicxe_pkg::OP_DIV, 4'd0, 4'd0, '0);
    // Rotates: a count above the register range is still legal, and a
    // count of zero still reports a write.
    send_instr(sicxe_pkg::OP_LDT, 4'd0, 4'd0, word_t'(24'hC3A501));
    send_instr(sicxe_pkg::OP_SHIFTL, sicxe_pkg::T_INDEX, 4'd15, '0);
    send_instr(sicxe_pkg::OP_SHIFTR, sicxe_pkg::T_INDEX, 4'd0, '0);
    send_instr(sicxe_pkg::OP_RMO, sicxe_pkg::T_INDEX, sicxe_pkg::SW_INDEX, '0);
    send_instr(sicxe_pkg::OP_CLEAR, sicxe_pkg::SW_INDEX, 4'd0, '0);
    send_instr(sicxe_pkg::OP_ADDR, 4'd15, sicxe_pkg::A_INDEX, '0);
    // Accumulator forms, starting from a character load.
    send_instr(sicxe_pkg::OP_LDCH, 4'd0, 4'd0, '1);
    send_instr(sicxe_pkg::OP_ADD, 4'd0, 4'd0, '1);
    send_instr(sicxe_pkg::OP_SUB, 4'd0, 4'd0, MAX_POS);
    send_instr(sicxe_pkg::OP_MUL, 4'd0, 4'd0, MAX_POS);
    send_instr(sicxe_pkg::OP_DIV, 4'd0, 4'd0, word_t'(24'hFFFFFE));
    send_instr(sicxe_pkg::OP_AND, 4'd0, 4'd0, word_t'(24'h0F0F0F));
    send_instr(sicxe_pkg::OP_OR, 4'd0, 4'd0, word_t'(24'hF00000));
    // A store opcode is not executed here.
    send_instr(8'h0C, 4'd3, 4'd7, word_t'(24'h123456));

    // Random part. Loads fill the file with interesting values, register
    // and accumulator forms work on them, and a few arbitrary opcodes mix
    // in. Fields an instruction does not use still carry random bits.
    // Halt is kept back, since only a reset would clear it.
    for (int n = 0; n < RANDOM_INSTRS; n++) begin
      roll = $urandom_range(0, 99);
      r1   = 4'($urandom_range(0, 15));
      r2   = 4'($urandom_range(0, 15));
      imm  = word_t'($urandom);
      if (roll < 30) begin
        op  = load_ops[$urandom_range(0, 6)];
        imm = pick_word();
      end else if (roll < 70) begin
        op = reg_ops[$urandom_range(0, 8)];
        r1 = pick_reg();
        if (op != sicxe_pkg::OP_SHIFTL && op != sicxe_pkg::OP_SHIFTR) r2 = pick_reg();
      end else if (roll < 92) begin
        op  = imm_ops[$urandom_range(0, 6)];
        imm = pick_word();
      end else begin
        op = 8'($urandom_range(0, 254));
      end
      send_instr(op, r1, r2, imm);
    end

    // Halt, then show that ordinary instructions only report halted.
    send_instr(sicxe_pkg::OP_HALT, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), '0);
    send_instr(sicxe_pkg::OP_LDA, 4'd0, 4'd0, MAX_POS);
    send_instr(sicxe_pkg::OP_ADDR, sicxe_pkg::X_INDEX, sicxe_pkg::A_INDEX, '0);
    send_instr(sicxe_pkg::OP_HALT, 4'd0, 4'd0, '0);
    in_valid <= 1'b0;

    // Wait for every outstanding result, then give the block time to show
    // any result it should not produce.
    while (tracker.pending_writebacks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (tracker.mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: a correct run finishes far inside this time.
  initial begin
    #(5_000_000);
    $display("Mismatches found");
    $finish;
  end

endmodule
